FILE: rtl/mie_pkg.sv
// Shared types and constants for the modular inverse unit.
package mie_pkg;

  // Default operand width; each field is one bit narrower.
  localparam int MIE_OPERAND_WIDTH = 64;

  // Controller states, one-hot.
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CHECK  = 5'b00010,
    ST_UP     = 5'b00100,
    ST_DOWN   = 5'b01000,
    ST_FINISH = 5'b10000
  } mie_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture a new request
    logic begin_step;  // start one quotient step from the current divisor
    logic shift_up;    // double the aligned divisor and coefficient
    logic sub_down;    // conditional subtract, then halve or close the step
    logic finish;      // reduce the coefficient and register the result
  } mie_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rc_zero;  // current remainder is zero: algorithm done
    logic up_ok;    // doubled divisor still fits under the dividend
    logic k_zero;   // divisor is back at its unshifted position
  } mie_status_t;

endpackage

FILE: rtl/mie_ctrl.sv
// Controller state machine of the modular inverse unit.
module mie_ctrl
  import mie_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  mie_status_t status,
  output mie_cmd_t    cmd,
  output logic        busy,
  output logic        done
);

  mie_state_t state;
  mie_state_t state_next;

  // Sequence the Euclid steps.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.rc_zero) begin
          state_next = ST_FINISH;
        end else begin
          cmd.begin_step = 1'b1;
          state_next     = ST_UP;
        end
      end
      ST_UP: begin
        if (status.up_ok) begin
          cmd.shift_up = 1'b1;
        end else begin
          state_next = ST_DOWN;
        end
      end
      ST_DOWN: begin
        cmd.sub_down = 1'b1;
        if (status.k_zero) begin
          state_next = ST_CHECK;
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold state and pulse done with the registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_FINISH);
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

FILE: rtl/mie_datapath.sv
// Remainder, coefficient and shift-subtract datapath of the modular inverse unit.
module mie_datapath
  import mie_pkg::*;
#(
  parameter int OPERAND_WIDTH = MIE_OPERAND_WIDTH
) (
  input  logic                     clk,
  input  mie_cmd_t                 cmd,
  input  logic [OPERAND_WIDTH-2:0] value,
  input  logic [OPERAND_WIDTH-2:0] modulus,
  output mie_status_t              status,
  output logic [OPERAND_WIDTH-2:0] inverse,
  output logic [OPERAND_WIDTH-2:0] common_divisor
);

  localparam int FW = OPERAND_WIDTH - 1;
  localparam int CW = FW + 2;
  localparam int KW = (FW > 1) ? $clog2(FW) : 1;

  logic [FW-1:0]        rp;   // r_prev, then running remainder
  logic [FW-1:0]        rc;   // r_cur
  logic signed [CW-1:0] sp;   // s_prev, then running coefficient
  logic signed [CW-1:0] sc;   // s_cur
  logic [FW-1:0]        d;    // r_cur aligned by k
  logic signed [CW-1:0] sd;   // s_cur aligned by k
  logic [KW-1:0]        k;
  logic [FW-1:0]        m;

  logic                 take;
  logic [FW-1:0]        rp_sub;
  logic signed [CW-1:0] sp_sub;
  logic signed [CW-1:0] m_ext;
  logic signed [CW-1:0] s_pos;
  logic signed [CW-1:0] s_red;

  // Compare and subtract the aligned divisor.
  assign take   = (d <= rp);
  assign rp_sub = take ? (rp - d) : rp;
  assign sp_sub = take ? (sp - sd) : sp;

  // Reduce the final coefficient into 0..modulus-1; it lies within one modulus.
  assign m_ext = signed'({2'b00, m});
  assign s_pos = sp[CW-1] ? (sp + m_ext) : sp;
  assign s_red = (s_pos >= m_ext) ? (s_pos - m_ext) : s_pos;

  assign status.rc_zero = (rc == '0);
  assign status.up_ok   = ({1'b0, d, 1'b0} <= {2'b00, rp});
  assign status.k_zero  = (k == '0);

  // Advance the datapath by command.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rp <= value;
      rc <= modulus;
      sp <= CW'(1);
      sc <= '0;
      m  <= modulus;
    end else if (cmd.begin_step) begin
      d  <= rc;
      sd <= sc;
      k  <= '0;
    end else if (cmd.shift_up) begin
      d  <= {d[FW-2:0], 1'b0};
      sd <= sd <<< 1;
      k  <= k + KW'(1);
    end else if (cmd.sub_down) begin
      if (k == '0) begin
        rp <= rc;
        rc <= rp_sub;
        sp <= sc;
        sc <= sp_sub;
      end else begin
        rp <= rp_sub;
        sp <= sp_sub;
        d  <= {1'b0, d[FW-1:1]};
        sd <= sd >>> 1;
        k  <= k - KW'(1);
      end
    end else if (cmd.finish) begin
      common_divisor <= rp;
      inverse        <= (m == '0) ? '0 : s_red[FW-1:0];
    end
  end

endmodule

FILE: rtl/modular_inverse_ext_euclid_unit.sv
// Each request loads the operands, then runs Euclid steps on the shared
// shift-subtract unit (doubling the aligned divisor, then subtracting and
// halving back), and finally reduces the coefficient and registers the result.
// Throughput: one request at a time; start is taken only while busy is low.
// The result is registered with done, which is high for one cycle and cannot be held off.
// Reset (rst, synchronous) returns the controller to idle and clears done.
module modular_inverse_ext_euclid_unit
  import mie_pkg::*;
#(
  parameter int OPERAND_WIDTH = MIE_OPERAND_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [OPERAND_WIDTH-2:0] value,
  input  logic [OPERAND_WIDTH-2:0] modulus,
  output logic                     busy,
  output logic                     done,
  output logic [OPERAND_WIDTH-2:0] inverse,
  output logic [OPERAND_WIDTH-2:0] common_divisor
);

  mie_cmd_t    cmd;
  mie_status_t status;

  // Sequence the steps.
  mie_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // Hold remainders and coefficients.
  mie_datapath #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .cmd            (cmd),
    .value          (value),
    .modulus        (modulus),
    .status         (status),
    .inverse        (inverse),
    .common_divisor (common_divisor)
  );

endmodule
